// ===== src/mos_pkg.sv =====
// Shared widths, defaults and cell control type for the sample median block.
package mos_pkg;

  localparam int DATA_W          = 16;
  localparam int MAX_SAMPLES_DEF = 16;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== src/mos_cell.sv =====
// One sorting cell: holds one sample and its valid bit, trades data with its neighbors.
module mos_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  mos_pkg::cell_ctrl_t           ctrl,
  input  logic [mos_pkg::DATA_W-1:0]    sample,
  input  logic [mos_pkg::DATA_W-1:0]    left_val,
  input  logic                          left_gt,
  input  logic                          left_valid,
  input  logic [mos_pkg::DATA_W-1:0]    right_val,
  output logic [mos_pkg::DATA_W-1:0]    val,
  output logic                          valid,
  output logic                          gt
);

  // An empty cell counts as larger than any sample.
  assign gt = !valid || (val > sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      valid <= valid | left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      // take the left neighbor's word if it moves up, else the new sample
      val <= left_gt ? left_val : sample;
    end else if (ctrl.shift) begin
      val <= right_val;
    end
  end

endmodule

// ===== src/mos_chain.sv =====
// Row of sorting cells that keeps the batch in ascending order.
module mos_chain #(
  parameter int MAX_SAMPLES = mos_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mos_pkg::cell_ctrl_t           ctrl,
  input  logic [mos_pkg::DATA_W-1:0]    sample,
  output logic [mos_pkg::DATA_W-1:0]    head0,
  output logic [mos_pkg::DATA_W-1:0]    head1,
  output logic [MAX_SAMPLES-1:0]        valid_vec
);

  logic [mos_pkg::DATA_W-1:0] vals [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0]     gts;

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic [mos_pkg::DATA_W-1:0] lv;
    logic                       lg;
    logic                       lvld;
    logic [mos_pkg::DATA_W-1:0] rv;

    if (i == 0) begin : g_first
      assign lv   = '0;
      assign lg   = 1'b0;
      assign lvld = 1'b1;
    end else begin : g_mid
      assign lv   = vals[i-1];
      assign lg   = gts[i-1];
      assign lvld = valid_vec[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_last
      assign rv = '0;
    end else begin : g_inner
      assign rv = vals[i+1];
    end

    mos_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample     (sample),
      .left_val   (lv),
      .left_gt    (lg),
      .left_valid (lvld),
      .right_val  (rv),
      .val        (vals[i]),
      .valid      (valid_vec[i]),
      .gt         (gts[i])
    );
  end

  assign head0 = vals[0];
  assign head1 = vals[1];

endmodule

// ===== src/median_of_samples_u16_top.sv =====
// Median of a batch of 16-bit samples: insertion cell row, drain sequencer, output register.
// Throughput: one sample per cycle while a batch fills; the cell row registers it in place as it is accepted.
// Drain: after the last word, the row shifts toward its head until the middle reaches it,
//   then the result register loads once it is free; s_tready is low meanwhile.
// The result may wait in its register while the next batch fills.
// Reset: synchronous; clears cell valid bits, count, overflow flag and m_tvalid at once.
module median_of_samples_u16_top #(
  parameter int MAX_SAMPLES = mos_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] sample
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [15:0] median
  output logic [0:0]                    m_tuser    // [0] dropped
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_SHIFT = 1'b1;

  logic                       state;
  logic [CW-1:0]              count;
  logic [CW-1:0]              rem;
  logic                       odd;
  logic                       ovf;
  logic [mos_pkg::DATA_W-1:0] head0;
  logic [mos_pkg::DATA_W-1:0] head1;
  logic [MAX_SAMPLES-1:0]     valid_vec;
  mos_pkg::cell_ctrl_t        ctrl;

  logic                       accept;
  logic                       full;
  logic [CW-1:0]              count_next;
  logic                       ovf_next;
  logic                       finish;
  logic [mos_pkg::DATA_W:0]   pair_sum;

  assign s_tready   = (state == ST_FILL);
  assign accept     = s_tvalid && s_tready;
  assign full       = (count == CW'(MAX_SAMPLES));
  assign count_next = full ? count : count + 1'b1;
  assign ovf_next   = ovf | full;
  assign finish     = (state == ST_SHIFT) && (rem == '0) && (!m_tvalid || m_tready);
  assign pair_sum   = {1'b0, head0} + {1'b0, head1};

  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = (state == ST_SHIFT) && (rem != '0);
  assign ctrl.clear  = finish;

  mos_chain #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample    (s_tdata),
    .head0     (head0),
    .head1     (head1),
    .valid_vec (valid_vec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        ST_FILL: begin
          if (accept) begin
            count <= count_next;
            ovf   <= ovf_next;
            if (s_tlast) begin
              state <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          if (finish) begin
            state <= ST_FILL;
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  // Drain distance: middle cell for odd counts, lower middle for even counts.
  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      odd <= count_next[0];
      rem <= (count_next >> 1) - {{(CW-1){1'b0}}, ~count_next[0]};
    end else if (ctrl.shift) begin
      rem <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata    <= odd ? head0 : pair_sum[mos_pkg::DATA_W:1];
      m_tuser[0] <= ovf;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES))
    else $error("fill count beyond capacity");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    valid_vec == MAX_SAMPLES'(((MAX_SAMPLES+1)'(1) << count) - 1'b1))
    else $error("cell valid bits do not match fill count");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> state == ST_SHIFT && count != '0)
    else $error("last word did not start drain");

  a_rem_counts: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT && rem != '0 |=> state == ST_SHIFT && rem == $past(rem) - 1'b1)
    else $error("drain counter skipped");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> !$past(finish))
    else $error("result loaded over a waiting word");

endmodule

// ===== sim/median_of_samples_u16_top_test.sv =====
// Testbench for the batch median block: random batches, predicted medians, stream stalls.
module median_of_samples_u16_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = mos_pkg::MAX_SAMPLES_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int BATCH_WORDS = 1450;

  typedef struct packed {
    logic [15:0] median;
    logic        dropped;
  } median_res_t;

  class median_board;
    logic [15:0]  cells[CAP];
    int unsigned  fill;
    bit           ovf;
    median_res_t  owed_medians[$];
    int           errors;

    function new();
      errors = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      foreach (cells[i]) cells[i] = '0;
      fill = 0;
      ovf  = 1'b0;
    endfunction

    // Place one accepted sample; on the batch end queue the median owed.
    function void note_word(logic [15:0] smp, logic lst);
      int unsigned pos;
      int unsigned half;
      logic [16:0] pair_sum;
      median_res_t r;
      if (fill >= CAP) begin
        ovf = 1'b1;
      end else begin
        pos = fill;
        while (pos > 0 && cells[pos-1] > smp) begin
          cells[pos] = cells[pos-1];
          pos--;
        end
        cells[pos] = smp;
        fill++;
      end
      if (lst) begin
        half = fill / 2;
        if (fill[0]) begin
          r.median = cells[half];
        end else begin
          pair_sum = {1'b0, cells[half-1]} + {1'b0, cells[half]};
          r.median = pair_sum[16:1];
        end
        r.dropped = ovf;
        owed_medians.push_back(r);
        clear_batch();
      end
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [15:0] med, logic drp);
      median_res_t e;
      if (owed_medians.size() == 0) begin
        report($sformatf("median %0d with none owed", med));
      end else begin
        e = owed_medians.pop_front();
        if (med !== e.median)
          report($sformatf("median got %0d want %0d", med, e.median));
        if (drp !== e.dropped)
          report($sformatf("dropped got %0b want %0b", drp, e.dropped));
      end
    endtask

    function int pending();
      return owed_medians.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  median_board board;
  int          send_idle;
  int          recv_stall;
  int          hold_seq;
  int          words_sent;
  int          cycles;

  median_of_samples_u16_top #(
    .MAX_SAMPLES(CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),     // [15:0] sample
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),     // [15:0] median
    .m_tuser(m_tuser)      // [0] dropped
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_seq advances.
  initial begin : receiver
    int seen_seq;
    int hold_left;
    seen_seq  = 0;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tdata, m_tuser[0]);
  end

  // Offer one word from a falling edge; return at the falling edge after acceptance.
  task send_word(input logic [15:0] smp, input logic lst);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = smp;
    s_tlast  = lst;
    do @(posedge clk); while (!s_tready);
    board.note_word(smp, lst);
    words_sent++;
    @(negedge clk);
  endtask

  task wait_drained();
    s_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task send_batch(input int n);
    int          flavor;
    logic [15:0] v;
    flavor = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      case (flavor)
        0: v = 16'($urandom_range(7));                    // many equal samples
        1: v = $urandom_range(1) ? 16'(16'hFFFF - $urandom_range(3))
                                 : 16'($urandom_range(3));
        default: v = 16'($urandom_range(16'hFFFF));
      endcase
      send_word(v, i == n - 1);
    end
  endtask

  function int batch_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(CAP + 1, CAP + 8);
    if (r < 15) return CAP;
    return $urandom_range(1, CAP - 1);
  endfunction

  initial begin : main
    int quota;
    board      = new();
    send_idle  = 0;
    recv_stall = 0;
    hold_seq   = 0;
    words_sent = 0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single samples at both extremes, a pair whose sum needs the 17th bit, a pair of both extremes.
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b1);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b1);
    // Descending run with duplicates, one past capacity so the last word is dropped.
    for (int i = 0; i <= CAP; i++)
      send_word(16'(((CAP - i) / 2) * 1000), i == CAP);
    wait_drained();

    quota = BATCH_WORDS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      // Long receiver hold-off with the sender running flat out: fills the block.
      if (ph == 0) hold_seq++;
      words_sent = 0;
      while (words_sent < quota) begin
        send_batch(batch_len());
        if (ph == 1 && words_sent >= quota / 2 && words_sent < quota / 2 + CAP)
          wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mos_pkg.sv
src/mos_cell.sv
src/mos_chain.sv
src/median_of_samples_u16_top.sv
sim/median_of_samples_u16_top_test.sv
